// ===== src/particle_pair_collision_resolve_unit_defines.svh =====
// Assertion macros shared by the collision resolve RTL.
`ifndef PARTICLE_PAIR_COLLISION_RESOLVE_UNIT_DEFINES_SVH
`define PARTICLE_PAIR_COLLISION_RESOLVE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PPCR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define PPCR_ASSERT_ON(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PPCR_ASSERT(label, clk, rst, prop)
`define PPCR_ASSERT_ON(label, clk, prop)
`endif
`endif

// ===== src/ppcr_pkg.sv =====
`timescale 1ns / 1ps
package ppcr_pkg;
  localparam int FW    = 24;
  localparam int FR    = 14;
  localparam int NF    = 12;
  localparam int DW    = FW + 1;
  localparam int MW    = FR;
  localparam int SQ_W  = 2 * FR;
  localparam int RT_W  = FR;
  localparam int SQ_ST = 7;
  localparam int DV_W  = 2 * FR;
  localparam int Q_W   = FR + 1;
  localparam int DV_ST = 5;
  localparam int NW    = FR + 2;
  localparam int SW    = 48;
  localparam int FMAX  = 2 ** (FW - 1) - 1;
  localparam int FMIN  = -(2 ** (FW - 1));

  typedef logic signed [FW-1:0] fld_t;
  typedef fld_t [NF-1:0] fields_t;
  typedef logic signed [DW-1:0] dif_t;

  typedef struct packed {
    fld_t a_pos_x;  fld_t a_pos_y;  fld_t a_pos_z;
    fld_t a_step_x; fld_t a_step_y; fld_t a_step_z;
    fld_t b_pos_x;  fld_t b_pos_y;  fld_t b_pos_z;
    fld_t b_step_x; fld_t b_step_y; fld_t b_step_z;
  } in_word_t;

  typedef struct packed {
    fld_t new_a_pos_x;  fld_t new_a_pos_y;  fld_t new_a_pos_z;
    fld_t new_a_step_x; fld_t new_a_step_y; fld_t new_a_step_z;
    fld_t new_b_pos_x;  fld_t new_b_pos_y;  fld_t new_b_pos_z;
    fld_t new_b_step_x; fld_t new_b_step_y; fld_t new_b_step_z;
  } out_word_t;

  typedef struct packed {
    fields_t               v;
    logic [2:0][MW-1:0]    m;
    logic [2:0]            neg;
    logic                  col;
  } ctx_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
  } sq_t;

  typedef struct packed {
    logic [DV_W-1:0] rem;
    logic [Q_W-1:0]  q;
  } dv_t;

  function automatic fld_t sat(input logic signed [SW-1:0] x);
    if (x > SW'(FMAX)) return fld_t'(FMAX);
    if (x < SW'(FMIN)) return fld_t'(FMIN);
    return x[FW-1:0];
  endfunction

  // One step of the bitwise square root; step k tests bit 2*(FR-1-k) of the root squared.
  function automatic sq_t sqrt_step(input sq_t s, input int k);
    logic [SQ_W-1:0] b;
    logic [SQ_W-1:0] t;
    sq_t r;
    b = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    t = s.res + b;
    if (s.rem >= t) begin
      r.rem = s.rem - t;
      r.res = (s.res >> 1) + b;
    end else begin
      r.rem = s.rem;
      r.res = s.res >> 1;
    end
    return r;
  endfunction

  // One restoring division step for quotient bit k.
  function automatic dv_t div_step(input dv_t s, input logic [RT_W-1:0] den, input int k);
    logic [DV_W:0] sh;
    dv_t r;
    sh = (DV_W + 1)'(den) << k;
    r = s;
    if ({1'b0, s.rem} >= sh) begin
      r.rem = s.rem - sh[DV_W-1:0];
      r.q   = s.q | (Q_W'(1) << k);
    end
    return r;
  endfunction
endpackage

// ===== src/ppcr_sqrt.sv =====
`timescale 1ns / 1ps
module ppcr_sqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [ppcr_pkg::SQ_W-1:0]      rad,
  output logic [ppcr_pkg::RT_W-1:0]      root
);
  localparam int SPS = (ppcr_pkg::RT_W + ppcr_pkg::SQ_ST - 1) / ppcr_pkg::SQ_ST;

  ppcr_pkg::sq_t pipe      [ppcr_pkg::SQ_ST];
  ppcr_pkg::sq_t pipe_next [ppcr_pkg::SQ_ST];

  always_comb begin
    ppcr_pkg::sq_t s;
    for (int st = 0; st < ppcr_pkg::SQ_ST; st++) begin
      if (st == 0) begin
        s.rem = rad;
        s.res = '0;
      end else begin
        s = pipe[st-1];
      end
      for (int j = 0; j < SPS; j++) begin
        if (st * SPS + j < ppcr_pkg::RT_W) s = ppcr_pkg::sqrt_step(s, st * SPS + j);
      end
      pipe_next[st] = s;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int st = 0; st < ppcr_pkg::SQ_ST; st++) pipe[st] <= pipe_next[st];
    end
  end

  assign root = pipe[ppcr_pkg::SQ_ST-1].res[ppcr_pkg::RT_W-1:0];
endmodule

// ===== src/ppcr_div.sv =====
`timescale 1ns / 1ps
module ppcr_div (
  input  logic                                clk,
  input  logic                                en,
  input  logic [2:0][ppcr_pkg::DV_W-1:0]      num,
  input  logic [ppcr_pkg::RT_W-1:0]           den,
  output logic [2:0][ppcr_pkg::Q_W-1:0]       quo,
  output logic [ppcr_pkg::RT_W-1:0]           den_out
);
  localparam int SPS = (ppcr_pkg::Q_W + ppcr_pkg::DV_ST - 1) / ppcr_pkg::DV_ST;

  ppcr_pkg::dv_t              lane      [ppcr_pkg::DV_ST][3];
  ppcr_pkg::dv_t              lane_next [ppcr_pkg::DV_ST][3];
  logic [ppcr_pkg::RT_W-1:0]  dline     [ppcr_pkg::DV_ST];

  always_comb begin
    ppcr_pkg::dv_t s;
    logic [ppcr_pkg::RT_W-1:0] dd;
    for (int st = 0; st < ppcr_pkg::DV_ST; st++) begin
      dd = (st == 0) ? den : dline[st-1];
      for (int l = 0; l < 3; l++) begin
        if (st == 0) begin
          s.rem = num[l];
          s.q   = '0;
        end else begin
          s = lane[st-1][l];
        end
        for (int j = 0; j < SPS; j++) begin
          if (st * SPS + j < ppcr_pkg::Q_W)
            s = ppcr_pkg::div_step(s, dd, ppcr_pkg::Q_W - 1 - (st * SPS + j));
        end
        lane_next[st][l] = s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int st = 0; st < ppcr_pkg::DV_ST; st++) begin
        dline[st] <= (st == 0) ? den : dline[st-1];
        for (int l = 0; l < 3; l++) lane[st][l] <= lane_next[st][l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) quo[l] = lane[ppcr_pkg::DV_ST-1][l].q;
  end
  assign den_out = dline[ppcr_pkg::DV_ST-1];
endmodule

// ===== src/particle_pair_collision_resolve_unit.sv =====
// An accepted input word passes stages A and B, the square root, the divider and stages E to J.
// Throughput: one word per cycle unless the output stalls; the square root (7 stages)
// and the three-lane normal divider (5 stages) are fully pipelined and set the depth.
// A stall at the output freezes the whole pipeline in place.
// Reset (synchronous, active high) clears the stage valid bits only.
`timescale 1ns / 1ps
`include "particle_pair_collision_resolve_unit_defines.svh"
module particle_pair_collision_resolve_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ppcr_pkg::in_word_t    in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ppcr_pkg::out_word_t   out_word
);
  localparam int FR = ppcr_pkg::FR;
  localparam int NF = ppcr_pkg::NF;
  localparam int NW = ppcr_pkg::NW;
  localparam int SW = ppcr_pkg::SW;
  localparam int LN = ppcr_pkg::SQ_ST + ppcr_pkg::DV_ST;
  localparam int EW = 29;
  localparam int TW = EW + FR + 2;
  localparam int PW = 2 * ppcr_pkg::DW - 9;
  localparam int KW = NW + EW;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage A: capture and form the separation.
  ppcr_pkg::fields_t fin, a_v;
  ppcr_pkg::dif_t    a_d [3];
  logic              a_valid;

  always_comb begin
    ppcr_pkg::fields_t raw;
    raw = ppcr_pkg::fields_t'(in_word);
    for (int i = 0; i < NF; i++) fin[i] = raw[NF-1-i];
  end

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (en) a_valid <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_v <= fin;
      for (int i = 0; i < 3; i++)
        a_d[i] <= ppcr_pkg::dif_t'(fin[i]) - ppcr_pkg::dif_t'(fin[6+i]);
    end
  end

  // Stage B: magnitudes and squares. A component of one or more already rules contact out.
  ppcr_pkg::ctx_t        b_ctx, b_ctx_next;
  logic [2*FR-1:0]       b_sq [3];
  logic                  b_valid;

  always_comb begin
    ppcr_pkg::dif_t mag;
    b_ctx_next.v   = a_v;
    b_ctx_next.col = 1'b1;
    for (int i = 0; i < 3; i++) begin
      mag = a_d[i][ppcr_pkg::DW-1] ? -a_d[i] : a_d[i];
      b_ctx_next.neg[i] = a_d[i][ppcr_pkg::DW-1];
      b_ctx_next.m[i]   = mag[FR-1:0];
      if (mag >= ppcr_pkg::dif_t'(2 ** FR)) b_ctx_next.col = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (en) b_valid <= a_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_ctx <= b_ctx_next;
      for (int i = 0; i < 3; i++)
        b_sq[i] <= (2 * FR)'(b_ctx_next.m[i]) * (2 * FR)'(b_ctx_next.m[i]);
    end
  end

  // Squared length feeds the root; the context rides alongside.
  logic [2*FR+1:0]   l2;
  ppcr_pkg::ctx_t    c_ctx;
  ppcr_pkg::ctx_t    cline [LN];
  logic              vline [LN];
  logic [ppcr_pkg::RT_W-1:0] root, sep_len;
  logic [2:0][ppcr_pkg::Q_W-1:0]  quo;
  logic [2:0][ppcr_pkg::DV_W-1:0] num;

  always_comb begin
    l2 = (2 * FR + 2)'(b_sq[0]) + (2 * FR + 2)'(b_sq[1]) + (2 * FR + 2)'(b_sq[2]);
    c_ctx = b_ctx;
    c_ctx.col = b_ctx.col && (l2 != '0) && (l2[2*FR+1:2*FR] == 2'b00);
  end

  ppcr_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (l2[2*FR-1:0]),
    .root (root)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) num[i] = {cline[ppcr_pkg::SQ_ST-1].m[i], FR'(0)};
  end

  ppcr_div u_div (
    .clk     (clk),
    .en      (en),
    .num     (num),
    .den     (root),
    .quo     (quo),
    .den_out (sep_len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < LN; s++) vline[s] <= 1'b0;
    end else if (en) begin
      vline[0] <= b_valid;
      for (int s = 1; s < LN; s++) vline[s] <= vline[s-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cline[0] <= c_ctx;
      for (int s = 1; s < LN; s++) cline[s] <= cline[s-1];
    end
  end

  // Stage E: signed normal and push magnitude.
  ppcr_pkg::fields_t      e_v;
  logic                   e_col, e_valid;
  logic [2:0]             e_neg;
  logic signed [NW-1:0]   e_n [3];
  logic [2*FR-1:0]        e_pm [3];
  logic [FR:0]            depth2;

  assign depth2 = (FR + 1)'(2 ** FR) - (FR + 1)'(sep_len);

  always_ff @(posedge clk) begin
    if (rst) e_valid <= 1'b0;
    else if (en) e_valid <= vline[LN-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e_v   <= cline[LN-1].v;
      e_col <= cline[LN-1].col;
      e_neg <= cline[LN-1].neg;
      for (int i = 0; i < 3; i++) begin
        e_n[i]  <= cline[LN-1].neg[i] ? -NW'(quo[i]) : NW'(quo[i]);
        e_pm[i] <= (2 * FR)'(quo[i]) * (2 * FR)'(depth2[FR:1]);
      end
    end
  end

  // Stage F: push both particles apart.
  ppcr_pkg::fields_t      f_v, f_v_next;
  logic                   f_col, f_valid;
  logic signed [NW-1:0]   f_n [3];

  always_comb begin
    logic signed [NW-1:0] p;
    f_v_next = e_v;
    for (int i = 0; i < 3; i++) begin
      p = e_neg[i] ? -NW'(e_pm[i][2*FR-1:FR]) : NW'(e_pm[i][2*FR-1:FR]);
      if (e_col) begin
        f_v_next[i]   = ppcr_pkg::sat(SW'(e_v[i])   + SW'(p));
        f_v_next[3+i] = ppcr_pkg::sat(SW'(e_v[3+i]) + SW'(p));
        f_v_next[6+i] = ppcr_pkg::sat(SW'(e_v[6+i]) - SW'(p));
        f_v_next[9+i] = ppcr_pkg::sat(SW'(e_v[9+i]) - SW'(p));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) f_valid <= 1'b0;
    else if (en) f_valid <= e_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f_v   <= f_v_next;
      f_col <= e_col;
      for (int i = 0; i < 3; i++) f_n[i] <= e_n[i];
    end
  end

  // Stage G: relative step times normal, per axis.
  ppcr_pkg::fields_t      g_v;
  logic                   g_col, g_valid;
  logic signed [NW-1:0]   g_n [3];
  logic signed [PW-1:0]   g_prod [3];

  always_ff @(posedge clk) begin
    if (rst) g_valid <= 1'b0;
    else if (en) g_valid <= f_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      g_v   <= f_v;
      g_col <= f_col;
      for (int i = 0; i < 3; i++) begin
        g_n[i]    <= f_n[i];
        g_prod[i] <= PW'(ppcr_pkg::dif_t'(f_v[3+i]) - ppcr_pkg::dif_t'(f_v[9+i]))
                     * PW'(f_n[i]);
      end
    end
  end

  // Stage H: exchange = 3 * dot / 2^16, truncated toward zero.
  ppcr_pkg::fields_t      h_v;
  logic                   h_kick, h_valid;
  logic signed [NW-1:0]   h_n [3];
  logic signed [EW-1:0]   h_exch;
  logic signed [TW-1:0]   dot3, dot3b;
  logic signed [EW-1:0]   exch;

  always_comb begin
    logic signed [TW-1:0] dot;
    dot   = TW'(g_prod[0]) + TW'(g_prod[1]) + TW'(g_prod[2]);
    dot3  = (dot <<< 1) + dot;
    dot3b = dot3 + (dot3[TW-1] ? TW'(2 ** (FR + 2) - 1) : TW'(0));
    exch  = dot3b[TW-1:FR+2];
  end

  always_ff @(posedge clk) begin
    if (rst) h_valid <= 1'b0;
    else if (en) h_valid <= g_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      h_v    <= g_v;
      h_exch <= exch;
      h_kick <= g_col && (exch > EW'(2 ** FR));
      for (int i = 0; i < 3; i++) h_n[i] <= g_n[i];
    end
  end

  // Stage I: kick products.
  ppcr_pkg::fields_t      i_v;
  logic                   i_kick, i_valid;
  logic signed [KW-1:0]   i_kp [3];

  always_ff @(posedge clk) begin
    if (rst) i_valid <= 1'b0;
    else if (en) i_valid <= h_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      i_v    <= h_v;
      i_kick <= h_kick;
      for (int i = 0; i < 3; i++) i_kp[i] <= KW'(h_n[i]) * KW'(h_exch);
    end
  end

  // Stage J: apply the kick and hold the result word.
  ppcr_pkg::fields_t o_v, o_v_next;

  always_comb begin
    logic signed [KW-1:0] kb;
    logic signed [KW-FR-1:0] e;
    o_v_next = i_v;
    for (int i = 0; i < 3; i++) begin
      kb = i_kp[i] + (i_kp[i][KW-1] ? KW'(2 ** FR - 1) : KW'(0));
      e  = kb[KW-1:FR];
      if (i_kick) begin
        o_v_next[3+i] = ppcr_pkg::sat(SW'(i_v[3+i]) + SW'(e));
        o_v_next[9+i] = ppcr_pkg::sat(SW'(i_v[9+i]) - SW'(e));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= i_valid;
  end
  always_ff @(posedge clk) begin
    if (en) o_v <= o_v_next;
  end

  always_comb begin
    ppcr_pkg::fields_t raw;
    for (int i = 0; i < NF; i++) raw[NF-1-i] = o_v[i];
    out_word = ppcr_pkg::out_word_t'(raw);
  end

  `PPCR_ASSERT_ON(a_stall_cause, clk, in_stall |-> (out_valid && out_stall))
  `PPCR_ASSERT(a_valid_advance, clk, rst, en |=> (out_valid == $past(i_valid)))
  `PPCR_ASSERT(a_hold_word, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
endmodule
